// ===== src/bspc_pkg.sv =====
// ----------------------------------------------------------------------------
// bspc_pkg: shared types and constants
// Codes, queue entry layout and fixed widths for the byte-stuffing codec.
// ----------------------------------------------------------------------------
package bspc_pkg;

  // fixed field widths
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TlenW   = 10;
  localparam int unsigned KindW   = 2;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned LengthW = 10;

  // stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic [ByteW-1:0] FrameCharReset = 8'h70;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_RX_BYTE  = 3'd0,
    FUNC_TX_START = 3'd1,
    FUNC_TX_DATA  = 3'd2,
    FUNC_TX_END   = 3'd3,
    FUNC_RX_FLUSH = 3'd4
  } func_e;

  typedef enum logic [KindW-1:0] {
    KIND_RX_DATA = 2'd0,
    KIND_RX_DONE = 2'd1,
    KIND_TX_BYTE = 2'd2
  } kind_e;

  // one queued job: one or two output words
  typedef struct packed {
    kind_e              kind;
    logic               pair;   // two words: data0 then data1
    logic [ByteW-1:0]   data0;
    logic [ByteW-1:0]   data1;
    logic [LengthW-1:0] num;    // rx index or rx length
  } bspc_entry_t;

  typedef struct packed {
    logic        valid;
    bspc_entry_t entry;
  } bspc_push_t;

  typedef struct packed {
    logic        empty;
    logic        full;
  } bspc_qstat_t;

endpackage

// ===== src/bspc_front.sv =====
// ----------------------------------------------------------------------------
// bspc_front: item classifier
// Accepts words, tracks rx escape, rx count and tx suppress, and queues jobs.
// ----------------------------------------------------------------------------
module bspc_front import bspc_pkg::*; #(
  parameter int unsigned MaxPacket = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             fire_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [ByteW-1:0] data_i,
  input  logic [TlenW-1:0] tlen_i,
  output bspc_push_t       push_o
);

  localparam int unsigned CntW = $clog2(MaxPacket + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPacket);
  localparam logic [31:0] MaxWide = 32'(MaxPacket);

  logic [ByteW-1:0] frame_q;
  logic             esc_q, esc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             supp_q, supp_d;
  logic [31:0]      cnt_ext;
  logic             is_fc;
  logic             store;

  assign cnt_ext = 32'(cnt_q);
  assign is_fc   = (data_i == frame_q);

  // frame character register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameCharReset;
    end else if (cfg_we_i) begin
      frame_q <= cfg_wdata_i;
    end
  end

  // classify the word and build the job
  always_comb begin
    esc_d  = esc_q;
    cnt_d  = cnt_q;
    supp_d = supp_q;
    store  = 1'b0;
    push_o = '0;
    if (fire_i) begin
      case (func_e'(func_i))
        FUNC_RX_BYTE: begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (!is_fc) begin
              push_o.valid      = 1'b1;
              push_o.entry.kind = KIND_RX_DONE;
              push_o.entry.num  = cnt_ext[LengthW-1:0];
              cnt_d             = '0;
            end else begin
              store = 1'b1;
            end
          end else if (is_fc) begin
            esc_d = 1'b1;
          end else begin
            store = 1'b1;
          end
          // data byte, dropped past the maximum length
          if (store && (cnt_q < CntMax)) begin
            push_o.valid       = 1'b1;
            push_o.entry.kind  = KIND_RX_DATA;
            push_o.entry.data0 = data_i;
            push_o.entry.num   = {1'b0, cnt_ext[IndexW-1:0]};
            cnt_d              = cnt_q + CntW'(1);
          end
        end
        FUNC_TX_START: begin
          supp_d = (32'(tlen_i) > MaxWide);
        end
        FUNC_TX_DATA: begin
          if (!supp_q) begin
            push_o.valid       = 1'b1;
            push_o.entry.kind  = KIND_TX_BYTE;
            push_o.entry.pair  = is_fc;
            push_o.entry.data0 = data_i;
            push_o.entry.data1 = data_i;
          end
        end
        FUNC_TX_END: begin
          if (supp_q) begin
            supp_d = 1'b0;
          end else begin
            push_o.valid       = 1'b1;
            push_o.entry.kind  = KIND_TX_BYTE;
            push_o.entry.pair  = 1'b1;
            push_o.entry.data0 = frame_q;
            push_o.entry.data1 = '0;
          end
        end
        FUNC_RX_FLUSH: begin
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // codec state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      cnt_q  <= '0;
      supp_q <= 1'b0;
    end else begin
      esc_q  <= esc_d;
      cnt_q  <= cnt_d;
      supp_q <= supp_d;
    end
  end

endmodule

// ===== src/bspc_queue.sv =====
// ----------------------------------------------------------------------------
// bspc_queue: job queue
// Two-entry queue between classifier and output stage.
// ----------------------------------------------------------------------------
module bspc_queue import bspc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bspc_push_t  push_i,
  input  logic        pop_i,
  output bspc_entry_t head_o,
  output bspc_qstat_t stat_o
);

  bspc_entry_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

// ===== src/bspc_back.sv =====
// ----------------------------------------------------------------------------
// bspc_back: output stage
// Expands queued jobs into one or two output words held in a register.
// ----------------------------------------------------------------------------
module bspc_back import bspc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bspc_entry_t         head_i,
  input  bspc_qstat_t         stat_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutDataW-1:0] data_o,
  output logic [KindW-1:0]    kind_o,
  output logic                last_o
);

  logic                valid_q;
  logic                phase_q, phase_d;
  logic [OutDataW-1:0] data_q, data_d;
  logic [KindW-1:0]    kind_q;
  logic                last_q, last_d;
  logic                load;
  logic [ByteW-1:0]    sel_byte;

  assign load  = (!valid_q || ready_i) && !stat_i.empty;
  assign pop_o = load && (!head_i.pair || phase_q);

  // word contents
  always_comb begin
    sel_byte = phase_q ? head_i.data1 : head_i.data0;
    last_d   = !head_i.pair || phase_q;
    phase_d  = head_i.pair && !phase_q;
    case (head_i.kind)
      KIND_RX_DATA: data_d = {5'b0, {LengthW{1'b0}}, head_i.num[IndexW-1:0], head_i.data0};
      KIND_RX_DONE: data_d = {5'b0, head_i.num, {IndexW{1'b0}}, {ByteW{1'b0}}};
      KIND_TX_BYTE: data_d = {5'b0, {LengthW{1'b0}}, {IndexW{1'b0}}, sel_byte};
      default:      data_d = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      phase_q <= phase_d;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      kind_q <= head_i.kind;
      last_q <= last_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign kind_o  = kind_q;
  assign last_o  = last_q;

endmodule

// ===== src/byte_stuffed_packet_codec.sv =====
// ----------------------------------------------------------------------------
// byte_stuffed_packet_codec: byte-stuffing framing codec
// Receive decoder and transmit encoder sharing one input and one output stream.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the operation (rx byte, tx start,
// tx data, tx end, rx flush); tdata carries the byte and the tx length.
// Output stream (m_axis): tuser gives the kind (rx data, rx packet done,
// tx line byte); tlast marks the final word caused by one input word.
// cfg_we_i/cfg_wdata_i load the frame character; write only when idle.
// The classifier writes the job into the queue when the input word is
// accepted; the output register loads it from the queue when it is empty
// or its current word is taken by the receiver.
// Throughput: one input word per cycle while the queue has room; a word
// that yields two output words (doubled frame char, packet trailer) holds
// the output register for both, so the queue fills and s_axis_tready drops.
// Words that yield nothing pass likewise, one per cycle, and only update state.
// Reset: frame character 0x70, escape, rx count and tx suppress cleared,
// queue and output register empty.
// When the receiver stalls, the output word holds, the queue fills and
// s_axis_tready goes low until room frees up.
// ----------------------------------------------------------------------------
module byte_stuffed_packet_codec import bspc_pkg::*; #(
  parameter int unsigned MAX_PACKET = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // byte_in[7:0], tx_length[17:8]
  input  logic [FuncW-1:0]    s_axis_tuser,  // func[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // byte_out[7:0], rx_index[16:8],
                                             // rx_length[26:17]
  output logic [KindW-1:0]    m_axis_tuser,  // kind[1:0]
  output logic                m_axis_tlast   // last
);

  bspc_push_t  push;
  bspc_entry_t head;
  bspc_qstat_t qstat;
  logic        pop;
  logic        fire;

  assign s_axis_tready = !qstat.full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  bspc_front #(
    .MaxPacket(MAX_PACKET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (fire),
    .func_i     (s_axis_tuser),
    .data_i     (s_axis_tdata[ByteW-1:0]),
    .tlen_i     (s_axis_tdata[ByteW+TlenW-1:ByteW]),
    .push_o     (push)
  );

  bspc_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .stat_o(qstat)
  );

  bspc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (qstat),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (m_axis_tdata),
    .kind_o (m_axis_tuser),
    .last_o (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // the second word of a pair follows right after the first is taken
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second word of a pair missing");

  // only tx words come in pairs
  a_pair_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_TX_BYTE)
    else $error("non-last word on an rx result");

  // a job is never offered while the queue is full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !qstat.full)
    else $error("job pushed into full queue");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: byte_stuffed_packet_codec self-checking bench
// Drives mixed rx line bytes, tx packets, flushes and spare codes through the
// input stream under several frame characters. A scoreboard predicts every
// output word and checks it in order; both sides stall at random till the last phase.
// ----------------------------------------------------------------------------
import bspc_pkg::*;

// one output word as the codec should emit it
typedef struct {
  logic [KindW-1:0]   kind;
  logic [ByteW-1:0]   data;
  logic [IndexW-1:0]  index;
  logic [LengthW-1:0] length;
  logic               last;
} codec_word_t;

class codec_scoreboard #(int unsigned MAX_LEN = 512);
  localparam int unsigned MaxPrinted = 40;

  // predicted codec state
  logic [ByteW-1:0] frame_char;
  bit               rx_escape;
  int unsigned      rx_count;
  bit               tx_suppress;

  codec_word_t expected_q[$];
  int errors;
  int words_in, rx_words, tx_words, flush_words, spare_words;
  int words_out, packets_closed, packets_dropped;

  function new();
    frame_char  = FrameCharReset;
    rx_escape   = 1'b0;
    rx_count    = 0;
    tx_suppress = 1'b0;
  endfunction

  function void set_frame_char(logic [ByteW-1:0] value);
    frame_char = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void push(logic [KindW-1:0] kind, logic [ByteW-1:0] data,
                     logic [IndexW-1:0] index, logic [LengthW-1:0] length,
                     logic last);
    codec_word_t w;
    w.kind   = kind;
    w.data   = data;
    w.index  = index;
    w.length = length;
    w.last   = last;
    expected_q.push_back(w);
  endfunction

  // rx decoder: escape, literal frame char, packet end, overflow drop
  function void decode_rx(logic [ByteW-1:0] b);
    if (rx_escape) begin
      rx_escape = 1'b0;
      if (b != frame_char) begin
        push(KIND_RX_DONE, '0, '0, LengthW'(rx_count), 1'b1);
        rx_count = 0;
        packets_closed++;
        return;
      end
    end else if (b == frame_char) begin
      rx_escape = 1'b1;
      return;
    end
    if (rx_count >= MAX_LEN) return;
    push(KIND_RX_DATA, b, IndexW'(rx_count), '0, 1'b1);
    rx_count++;
  endfunction

  // note one accepted input word and queue what it should produce
  function void note_word(logic [FuncW-1:0] func, logic [ByteW-1:0] b,
                          logic [TlenW-1:0] tlen);
    words_in++;
    case (func)
      FUNC_RX_BYTE: begin
        rx_words++;
        decode_rx(b);
      end
      FUNC_TX_START: begin
        tx_words++;
        tx_suppress = (tlen > MAX_LEN);
        if (tx_suppress) packets_dropped++;
      end
      FUNC_TX_DATA: begin
        tx_words++;
        if (!tx_suppress) begin
          if (b == frame_char) begin
            push(KIND_TX_BYTE, frame_char, '0, '0, 1'b0);
          end
          push(KIND_TX_BYTE, b, '0, '0, 1'b1);
        end
      end
      FUNC_TX_END: begin
        tx_words++;
        if (tx_suppress) begin
          tx_suppress = 1'b0;
        end else begin
          push(KIND_TX_BYTE, frame_char, '0, '0, 1'b0);
          push(KIND_TX_BYTE, '0, '0, '0, 1'b1);
        end
      end
      FUNC_RX_FLUSH: begin
        flush_words++;
        rx_count = 0;
      end
      default: spare_words++;
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("  mismatch @%0t: %s", $time, msg);
  endtask

  // compare one output word with the oldest prediction
  task check_word(codec_word_t got);
    codec_word_t exp;
    words_out++;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected word kind=%0d byte=%02h idx=%0d len=%0d last=%0b",
                       got.kind, got.data, got.index, got.length, got.last));
      return;
    end
    exp = expected_q.pop_front();
    if (got.kind !== exp.kind || got.data !== exp.data || got.index !== exp.index ||
        got.length !== exp.length || got.last !== exp.last) begin
      report($sformatf("got kind=%0d byte=%02h idx=%0d len=%0d last=%0b, exp %0d %02h %0d %0d %0b",
                       got.kind, got.data, got.index, got.length, got.last,
                       exp.kind, exp.data, exp.index, exp.length, exp.last));
    end
  endtask

  task close_out();
    if (expected_q.size() != 0)
      report($sformatf("%0d expected words never arrived", expected_q.size()));
  endtask
endclass

module testbench;
  localparam int unsigned MaxPacket   = 512;
  localparam int unsigned DrainCycles = 10;
  localparam logic [FuncW-1:0] FuncSpareLo = 3'd5;
  localparam logic [FuncW-1:0] FuncSpareHi = 3'd7;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [ByteW-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [FuncW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int phase_words;
  logic [ByteW-1:0] cur_frame_char = FrameCharReset;

  codec_scoreboard #(MaxPacket) sb;

  byte_stuffed_packet_codec #(
    .MAX_PACKET(MaxPacket)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("** byte_stuffed_packet_codec: FAILED **");
    $finish;
  end

  // receiver: stall bursts, then ready stretches
  initial begin
    forever begin
      if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    codec_word_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = m_axis_tuser;
      got.data   = m_axis_tdata[7:0];
      got.index  = m_axis_tdata[16:8];
      got.length = m_axis_tdata[26:17];
      got.last   = m_axis_tlast;
      sb.check_word(got);
    end
  end

  // one input word, with an optional idle burst ahead of it
  task send_word(logic [FuncW-1:0] func, logic [ByteW-1:0] b, logic [TlenW-1:0] tlen);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, tlen, b};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(func, b, tlen);
    if (func < FuncSpareLo) phase_words++;
  endtask

  // stop sending and let every predicted word come out
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task write_frame_char(logic [ByteW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_frame_char(value);
    cur_frame_char = value;
  endtask

  // data byte biased toward the frame character
  function logic [ByteW-1:0] pick_byte();
    if ($urandom_range(0, 4) == 0) return cur_frame_char;
    return ByteW'($urandom_range(0, 255));
  endfunction

  // well-formed rx packet: stuffed payload, then frame char and terminator
  task send_rx_packet(int n);
    logic [ByteW-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = pick_byte();
      send_word(FUNC_RX_BYTE, b, TlenW'($urandom));
      if (b == cur_frame_char) send_word(FUNC_RX_BYTE, b, TlenW'($urandom));
    end
    send_word(FUNC_RX_BYTE, cur_frame_char, TlenW'($urandom));
    do b = ByteW'($urandom); while (b == cur_frame_char);
    send_word(FUNC_RX_BYTE, b, TlenW'($urandom));
  endtask

  task send_tx_packet(int n);
    logic [TlenW-1:0] tlen;
    tlen = ($urandom_range(0, 9) < 7) ? TlenW'(n) : TlenW'($urandom_range(0, 1023));
    send_word(FUNC_TX_START, ByteW'($urandom), tlen);
    for (int i = 0; i < n; i++) send_word(FUNC_TX_DATA, pick_byte(), TlenW'($urandom));
    send_word(FUNC_TX_END, ByteW'($urandom), TlenW'($urandom));
  endtask

  // random phase: mostly packets, some flushes and noise
  task run_phase(int target, bit pause_midway);
    int pick;
    bit paused;
    paused = 1'b0;
    phase_words = 0;
    while (phase_words < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_rx_packet((pick < 4) ? $urandom_range(11, 40) : $urandom_range(0, 10));
      end else if (pick < 75) begin
        send_tx_packet($urandom_range(0, 10));
      end else if (pick < 82) begin
        // partial packet cut short by a flush
        repeat ($urandom_range(0, 4)) send_word(FUNC_RX_BYTE, pick_byte(), TlenW'($urandom));
        send_word(FUNC_RX_FLUSH, ByteW'($urandom), TlenW'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(FuncSpareHi & FuncW'($urandom), pick_byte(), TlenW'($urandom));
      end
      if (pause_midway && !paused && phase_words >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [ByteW-1:0] rand_char;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default frame char 0x70
    send_word(FUNC_RX_BYTE, 8'h00, 10'h3FF);
    send_word(FUNC_RX_BYTE, 8'hFF, 10'h000);
    send_word(FUNC_RX_BYTE, 8'h70, 10'h000);  // escape
    send_word(FUNC_RX_BYTE, 8'h70, 10'h000);  // literal frame char
    send_word(FUNC_RX_BYTE, 8'h70, 10'h000);
    send_word(FUNC_RX_BYTE, 8'h00, 10'h000);  // packet end, length 3
    send_word(FUNC_RX_BYTE, 8'h55, 10'h000);
    send_word(FUNC_RX_FLUSH, 8'h00, 10'h000); // drops the partial packet
    send_word(FUNC_RX_BYTE, 8'h70, 10'h000);
    send_word(FUNC_RX_FLUSH, 8'hFF, 10'h3FF); // escape survives the flush
    send_word(FUNC_RX_BYTE, 8'h12, 10'h000);  // ends an empty packet
    send_word(FUNC_TX_START, 8'h00, 10'd512); // at the limit: sent
    send_word(FUNC_TX_DATA, 8'h70, 10'h000);  // doubled
    send_word(FUNC_TX_DATA, 8'hFF, 10'h000);
    send_word(FUNC_TX_END, 8'h00, 10'h000);   // trailer
    send_word(FUNC_TX_START, 8'h00, 10'h3FF); // oversize: suppressed
    send_word(FUNC_TX_DATA, 8'h70, 10'h000);
    send_word(FUNC_TX_END, 8'h00, 10'h000);
    send_word(FUNC_TX_DATA, 8'h00, 10'h000);  // data outside a packet
    send_word(FUNC_TX_START, 8'h00, 10'd513);
    send_word(FUNC_TX_END, 8'h00, 10'h000);
    send_word(FUNC_TX_END, 8'h00, 10'h000);   // not suppressed any more
    send_word(FuncSpareLo, 8'h70, 10'h3FF);   // spare codes are ignored
    send_word(FuncSpareHi, 8'h70, 10'h3FF);
    send_word(FUNC_TX_START, 8'hFF, 10'd0);

    // frame char 0x00, with one packet past the length limit
    write_frame_char(8'h00);
    send_rx_packet(MaxPacket + 8);
    run_phase(60, 1'b0);

    write_frame_char(8'hFF);
    run_phase(70, 1'b1);

    do rand_char = ByteW'($urandom); while (rand_char inside {8'h00, 8'hFF});
    write_frame_char(rand_char);
    run_phase(70, 1'b0);

    // closing phase back at the reset value, no idling on either side
    write_frame_char(FrameCharReset);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(60, 1'b0);

    wait_drained();
    sb.close_out();

    $display("Covered %0d input words (%0d rx, %0d tx, %0d flush, %0d spare), %0d output words,",
             sb.words_in, sb.rx_words, sb.tx_words, sb.flush_words, sb.spare_words,
             sb.words_out);
    $display("%0d rx packets closed, %0d tx packets suppressed, frame chars 00/FF/%02h/70.",
             sb.packets_closed, sb.packets_dropped, rand_char);
    if (sb.errors == 0) begin
      $display("** byte_stuffed_packet_codec: PASSED **");
    end else begin
      $display("** byte_stuffed_packet_codec: FAILED **");
    end
    $finish;
  end
endmodule
